// ===== rtl/core/csp_pkg.sv =====
// Shared types and constants of the CIGAR string parser.
`default_nettype none
package csp_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] CHAR_M = 8'h4D;
	localparam logic [7:0] CHAR_X = 8'h58;
	localparam logic [7:0] CHAR_I = 8'h49;
	localparam logic [7:0] CHAR_D = 8'h44;

	typedef enum logic [1:0] {
		OP_M = 2'd0,
		OP_X = 2'd1,
		OP_I = 2'd2,
		OP_D = 2'd3
	} op_kind_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NO_LENGTH  = 2'd1,
		ST_BAD_LETTER = 2'd2,
		ST_NO_CLOSE   = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_mark;
	} sym_word_t;

	typedef struct packed {
		logic                   is_summary;
		op_kind_t               op_kind;
		logic [LENGTH_BITS-1:0] op_length;
		logic [LENGTH_BITS-1:0] reference_total;
		logic [LENGTH_BITS-1:0] alternate_total;
		status_t                status;
	} res_word_t;

	// Command passed from the front to the back through the queue.
	typedef struct packed {
		logic                   is_summary;
		op_kind_t               op_kind;
		logic [LENGTH_BITS-1:0] op_length;
		status_t                status;
	} cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/cigar_string_parser_unit.sv =====
// Top level of the CIGAR string parser.
`default_nettype none
// The parser takes one ASCII character per word on the sym channel, at one
// word per clock cycle as long as the command queue has room, and ends each
// string with a word whose end_mark is set. Digits build a length that
// saturates at all ones; each M, X, I or D letter then yields one result
// word carrying the operation, its length and the running reference and
// alternate totals (already including it). The end word yields a summary
// word with the totals and the status, and returns the parser to its reset
// state for the next string. After the first error (a letter with no
// length, an unknown letter, or a length left open at the end) characters
// are dropped until the end word. Characters that yield no result go no
// further than the front end. A result takes this path to the res channel:
// the front decodes and pushes into a two-entry queue at the accept edge, and
// the back end pops one command per cycle, while its output register is empty
// or the res channel takes it, into that register, so a stalled res channel
// fills the queue before sym_ready drops.
module cigar_string_parser_unit import csp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      sym_valid,
	output logic           sym_ready,
	input  wire sym_word_t sym_word,
	output logic           res_valid,
	input  wire logic      res_ready,
	output res_word_t      res_word
);

	logic cmd_push;
	cmd_t cmd_in;
	logic cmd_pop;
	logic queue_full;
	logic queue_not_empty;
	cmd_t cmd_head;

	// Front: classify each character, hold the length and error state.
	csp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sym_valid  (sym_valid),
		.sym_ready  (sym_ready),
		.sym_word   (sym_word),
		.queue_full (queue_full),
		.cmd_push   (cmd_push),
		.cmd_word   (cmd_in)
	);

	// Queue: decouple the character side from a stalled result side.
	csp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_word (cmd_in),
		.pop       (cmd_pop),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.head_word (cmd_head)
	);

	// Back: advance the totals and register each result word.
	csp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ready (queue_not_empty),
		.cmd_word  (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

endmodule
`default_nettype wire

// ===== rtl/core/csp_front.sv =====
// Front end: takes characters, builds lengths, tracks errors, issues commands.
`default_nettype none
module csp_front import csp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      sym_valid,
	output logic           sym_ready,
	input  wire sym_word_t sym_word,
	input  wire logic      queue_full,
	output logic           cmd_push,
	output cmd_t           cmd_word
);

	logic [LENGTH_BITS-1:0] acc_q;
	logic                   digits_q;
	status_t                error_q;

	logic                   accept;
	logic                   is_digit;
	logic                   known;
	op_kind_t               kind;
	logic [LENGTH_BITS+3:0] acc_next_wide;
	logic [LENGTH_BITS-1:0] acc_next;

	assign sym_ready = !queue_full;
	assign accept    = sym_valid && sym_ready;
	assign is_digit  = sym_word.symbol inside {[8'h30:8'h39]};

	always_comb begin
		known = 1'b1;
		kind  = OP_M;
		case (sym_word.symbol)
			CHAR_M:  kind = OP_M;
			CHAR_X:  kind = OP_X;
			CHAR_I:  kind = OP_I;
			CHAR_D:  kind = OP_D;
			default: known = 1'b0;
		endcase
	end

	// acc * 10 + digit, saturated when it spills past the length width
	always_comb begin
		acc_next_wide = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
			+ {{LENGTH_BITS{1'b0}}, sym_word.symbol[3:0]};
		if (acc_next_wide[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) begin
			acc_next = {LENGTH_BITS{1'b1}};
		end else begin
			acc_next = acc_next_wide[LENGTH_BITS-1:0];
		end
	end

	always_comb begin
		cmd_push            = 1'b0;
		cmd_word.is_summary = 1'b0;
		cmd_word.op_kind    = kind;
		cmd_word.op_length  = acc_q;
		cmd_word.status     = ST_OK;
		if (accept) begin
			if (sym_word.end_mark) begin
				cmd_push            = 1'b1;
				cmd_word.is_summary = 1'b1;
				cmd_word.op_kind    = OP_M;
				cmd_word.op_length  = '0;
				if (error_q == ST_OK && digits_q) begin
					cmd_word.status = ST_NO_CLOSE;
				end else begin
					cmd_word.status = error_q;
				end
			end else if (error_q == ST_OK && !is_digit && digits_q && known) begin
				cmd_push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			digits_q <= 1'b0;
			error_q  <= ST_OK;
		end else if (accept) begin
			if (sym_word.end_mark) begin
				acc_q    <= '0;
				digits_q <= 1'b0;
				error_q  <= ST_OK;
			end else if (error_q == ST_OK) begin
				if (is_digit) begin
					acc_q    <= acc_next;
					digits_q <= 1'b1;
				end else if (!digits_q) begin
					error_q <= ST_NO_LENGTH;
				end else begin
					acc_q    <= '0;
					digits_q <= 1'b0;
					if (!known) begin
						error_q <= ST_BAD_LETTER;
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/csp_queue.sv =====
// Short command queue between the front and the back.
`default_nettype none
module csp_queue import csp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_word,
	input  wire logic pop,
	output logic      full,
	output logic      not_empty,
	output cmd_t      head_word
);

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;

	assign full      = (count_q == CNT_BITS'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/csp_back.sv =====
// Back end: keeps the running totals and drives the result register.
`default_nettype none
module csp_back import csp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_ready,
	input  wire cmd_t cmd_word,
	output logic      cmd_pop,
	output logic      res_valid,
	input  wire logic res_ready,
	output res_word_t res_word
);

	logic [LENGTH_BITS-1:0] ref_sum_q;
	logic [LENGTH_BITS-1:0] alt_sum_q;
	logic                   valid_q;
	res_word_t              res_q;

	logic [LENGTH_BITS:0]   ref_add;
	logic [LENGTH_BITS:0]   alt_add;
	logic [LENGTH_BITS-1:0] ref_new;
	logic [LENGTH_BITS-1:0] alt_new;

	assign res_valid = valid_q;
	assign res_word  = res_q;
	assign cmd_pop   = cmd_ready && (!valid_q || res_ready);

	// saturating adds; I leaves the reference total alone, D the alternate
	always_comb begin
		ref_add = {1'b0, ref_sum_q} + {1'b0, cmd_word.op_length};
		alt_add = {1'b0, alt_sum_q} + {1'b0, cmd_word.op_length};
		ref_new = ref_add[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : ref_add[LENGTH_BITS-1:0];
		alt_new = alt_add[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : alt_add[LENGTH_BITS-1:0];
		if (cmd_word.op_kind == OP_I) begin
			ref_new = ref_sum_q;
		end
		if (cmd_word.op_kind == OP_D) begin
			alt_new = alt_sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			ref_sum_q <= '0;
			alt_sum_q <= '0;
		end else if (cmd_pop) begin
			valid_q <= 1'b1;
			if (cmd_word.is_summary) begin
				ref_sum_q <= '0;
				alt_sum_q <= '0;
			end else begin
				ref_sum_q <= ref_new;
				alt_sum_q <= alt_new;
			end
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			res_q.is_summary <= cmd_word.is_summary;
			res_q.op_kind    <= cmd_word.op_kind;
			res_q.op_length  <= cmd_word.op_length;
			res_q.status     <= cmd_word.status;
			if (cmd_word.is_summary) begin
				res_q.reference_total <= ref_sum_q;
				res_q.alternate_total <= alt_sum_q;
			end else begin
				res_q.reference_total <= ref_new;
				res_q.alternate_total <= alt_new;
			end
		end
	end

endmodule
`default_nettype wire

// ===== tb/cigar_string_parser_unit_tb.sv =====
// Self-checking testbench for the CIGAR string parser: directed and random strings.
module cigar_string_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csp_pkg::*;

	localparam logic [7:0] CHAR_0 = 8'h30;
	localparam logic [7:0] CHAR_9 = 8'h39;
	localparam logic [63:0] LEN_MAX = 64'({LENGTH_BITS{1'b1}});

	localparam int RANDOM_WORDS = 1500;
	localparam int CHOKE_AT = 600;     // sym words sent before the long res hold-off
	localparam int HOLD_CYCLES = 400;  // length of that hold-off
	localparam int DRAIN_CYCLES = 20;  // quiet cycles after the last expected result
	localparam int IDLE_LIMIT = 5000;  // cycles with no handshake before giving up

	// Predict parser results from accepted sym words and check res words against them.
	class cigar_tally;
		logic [LENGTH_BITS-1:0] run_length;
		bit                     have_digits;
		logic [LENGTH_BITS-1:0] ref_total;
		logic [LENGTH_BITS-1:0] alt_total;
		status_t                fault;
		res_word_t              due_results[$];
		int                     fail_count;
		int                     checked;

		function new();
			fail_count = 0;
			checked = 0;
			restart();
		endfunction

		function void restart();
			run_length = '0;
			have_digits = 1'b0;
			ref_total = '0;
			alt_total = '0;
			fault = ST_OK;
		endfunction

		// Append one predicted word at the tail of the list.
		function void add_due(res_word_t r);
			due_results = {due_results, r};
		endfunction

		function logic [LENGTH_BITS-1:0] sat_sum(logic [LENGTH_BITS-1:0] a,
				logic [LENGTH_BITS-1:0] b);
			logic [64:0] s;
			s = 65'(a) + 65'(b);
			if (s > 65'(LEN_MAX))
				return LEN_MAX[LENGTH_BITS-1:0];
			return s[LENGTH_BITS-1:0];
		endfunction

		// Advance the parser state by one accepted word; queue any result it yields.
		function void note_symbol(sym_word_t w);
			res_word_t  r;
			logic [63:0] grown;
			logic [LENGTH_BITS-1:0] taken;
			op_kind_t   kind;
			r = '0;
			if (w.end_mark) begin
				// A length with no closing letter only counts when nothing failed earlier.
				if (fault == ST_OK && have_digits)
					fault = ST_NO_CLOSE;
				r.is_summary = 1'b1;
				r.op_kind = OP_M;
				r.op_length = '0;
				r.reference_total = ref_total;
				r.alternate_total = alt_total;
				r.status = fault;
				add_due(r);
				restart();
				return;
			end
			// Drop everything between the first error and the end word.
			if (fault != ST_OK)
				return;
			if (w.symbol >= CHAR_0 && w.symbol <= CHAR_9) begin
				grown = 64'(run_length) * 64'd10 + 64'(w.symbol - CHAR_0);
				run_length = (grown > LEN_MAX) ? LEN_MAX[LENGTH_BITS-1:0]
					: grown[LENGTH_BITS-1:0];
				have_digits = 1'b1;
				return;
			end
			// Any non-digit without a length before it, known letter or not.
			if (!have_digits) begin
				fault = ST_NO_LENGTH;
				return;
			end
			taken = run_length;
			run_length = '0;
			have_digits = 1'b0;
			case (w.symbol)
				CHAR_M: kind = OP_M;
				CHAR_X: kind = OP_X;
				CHAR_I: kind = OP_I;
				CHAR_D: kind = OP_D;
				default: begin
					fault = ST_BAD_LETTER;
					return;
				end
			endcase
			if (kind != OP_I)
				ref_total = sat_sum(ref_total, taken);
			if (kind != OP_D)
				alt_total = sat_sum(alt_total, taken);
			r.is_summary = 1'b0;
			r.op_kind = kind;
			r.op_length = taken;
			r.reference_total = ref_total;
			r.alternate_total = alt_total;
			r.status = ST_OK;
			add_due(r);
		endfunction

		task report(string msg);
			fail_count++;
			if (fail_count <= 40)
				$display("%0t ns: MISMATCH res word %0d: %s", $time, checked, msg);
		endtask

		task check_result(res_word_t got);
			res_word_t want;
			if (due_results.size() == 0) begin
				report($sformatf("unexpected word %h", got));
				checked++;
				return;
			end
			want = due_results.pop_front();
			if (got.is_summary !== want.is_summary)
				report($sformatf("is_summary %0d, want %0d", got.is_summary, want.is_summary));
			if (got.op_kind !== want.op_kind)
				report($sformatf("op_kind %0d, want %0d", got.op_kind, want.op_kind));
			if (got.op_length !== want.op_length)
				report($sformatf("op_length %0d, want %0d", got.op_length, want.op_length));
			if (got.reference_total !== want.reference_total)
				report($sformatf("reference_total %0d, want %0d",
					got.reference_total, want.reference_total));
			if (got.alternate_total !== want.alternate_total)
				report($sformatf("alternate_total %0d, want %0d",
					got.alternate_total, want.alternate_total));
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			checked++;
		endtask

		task flag_leftovers();
			if (due_results.size() != 0)
				report($sformatf("%0d expected words never arrived", due_results.size()));
		endtask
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      sym_valid = 1'b0;
	logic      sym_ready;
	sym_word_t sym_word = '0;
	logic      res_valid;
	logic      res_ready = 1'b0;
	res_word_t res_word;

	cigar_tally tally = new();
	int  idle_cycles = 0;
	int  sent = 0;
	bit  calm = 1'b0;   // no sender gaps for the current string
	bit  choke = 1'b0;  // ask the res side for one long hold-off

	cigar_string_parser_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_ready (sym_ready),
		.sym_word  (sym_word),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_word  (res_word)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Sample both channels at the rising edge; the inputs only move at the falling edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sym_valid && sym_ready)
				tally.note_symbol(sym_word);
			if (res_valid && res_ready)
				tally.check_result(res_word);
			if ((sym_valid && sym_ready) || (res_valid && res_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : watchdog
		wait (idle_cycles >= IDLE_LIMIT);
		$display("cigar_string_parser_unit_tb failed");
		$finish;
	end

	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(99);
		if (roll < 70)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one word after a random gap and hold it until it is taken.
	task automatic put_word(sym_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			sym_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		sym_valid <= 1'b1;
		sym_word <= w;
		@(posedge clk);
		while (!sym_ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic send_char(logic [7:0] c);
		sym_word_t w;
		w.symbol = c;
		w.end_mark = 1'b0;
		put_word(w);
	endtask

	// The end word carries a random symbol, which the block must ignore.
	task automatic send_end();
		sym_word_t w;
		w.symbol = 8'($urandom_range(0, 255));
		w.end_mark = 1'b1;
		put_word(w);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	function automatic logic [7:0] op_letter();
		case ($urandom_range(0, 3))
			0: return CHAR_M;
			1: return CHAR_X;
			2: return CHAR_I;
			default: return CHAR_D;
		endcase
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c >= CHAR_0 && c <= CHAR_9);
		return c;
	endfunction

	function automatic logic [7:0] unknown_letter();
		logic [7:0] c;
		do
			c = non_digit();
		while (c == CHAR_M || c == CHAR_X || c == CHAR_I || c == CHAR_D);
		return c;
	endfunction

	// Send a decimal length: mostly short, some with leading zeros, some that saturate.
	task automatic send_length();
		int          sel;
		int          k;
		logic [63:0] v;
		string       txt;
		sel = $urandom_range(99);
		if (sel < 50)
			txt = $sformatf("%0d", $urandom_range(1, 999));
		else if (sel < 62)
			txt = $sformatf("%0d", $urandom_range(0, 9));
		else if (sel < 70)
			txt = {"00", $sformatf("%0d", $urandom_range(0, 99))};
		else if (sel < 82)
			txt = $sformatf("%0d", $urandom());
		else if (sel < 92) begin
			txt = "";
			k = $urandom_range(10, 13);
			repeat (k) txt = {txt, $sformatf("%0d", $urandom_range(0, 9))};
		end else begin
			// Straddle the all-ones length.
			v = 64'd4294967290 + 64'($urandom_range(0, 9));
			txt = $sformatf("%0d", v);
		end
		send_text(txt);
	endtask

	// Mostly well-formed; the rest break in an error way or go random; most add noise.
	task automatic random_string();
		int n_ops;
		int flaw;
		calm = ($urandom_range(99) < 25);
		n_ops = $urandom_range(0, 6);
		repeat (n_ops) begin
			send_length();
			send_char(op_letter());
		end
		if ($urandom_range(99) >= 80) begin
			flaw = $urandom_range(0, 3);
			case (flaw)
				0: send_char(non_digit());
				1: begin
					send_length();
					send_char(unknown_letter());
				end
				2: send_length();
				default: repeat ($urandom_range(1, 8)) send_char(8'($urandom_range(0, 255)));
			endcase
			if (flaw != 2)
				repeat ($urandom_range(0, 4)) send_char(8'($urandom_range(0, 255)));
		end
		send_end();
	endtask

	function automatic int pick_stall();
		int roll;
		roll = $urandom_range(99);
		if (roll < 35)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Res side: bursts of ready with random stalls between, plus one long hold-off.
	initial begin : res_side
		int stall;
		int burst;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (choke) begin
				stall = HOLD_CYCLES;
				choke = 1'b0;
			end else begin
				stall = pick_stall();
			end
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ready <= 1'b1;
			burst = ($urandom_range(99) < 90) ? $urandom_range(1, 30) : $urandom_range(100, 300);
			repeat (burst - 1) @(negedge clk);
		end
	end

	initial begin : sym_side
		bit choked;
		choked = 1'b0;
		@(posedge arst_n);

		// Directed strings: every operation, empty string, the error kinds,
		// symbol extremes and lower case.
		send_text("10M5X3I7D");
		send_end();
		send_end();
		send_char(8'h00);
		send_end();
		send_text("7");
		send_char(8'hFF);
		send_end();
		send_text("12");
		send_end();
		send_text("4m");
		send_end();

		while (sent < RANDOM_WORDS) begin
			if (!choked && sent >= CHOKE_AT) begin
				choke = 1'b1;
				choked = 1'b1;
			end
			random_string();
		end

		@(negedge clk);
		sym_valid <= 1'b0;
		while (tally.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		tally.flag_leftovers();
		if (tally.fail_count == 0)
			$display("cigar_string_parser_unit_tb passed");
		else
			$display("cigar_string_parser_unit_tb failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/csp_pkg.sv
rtl/core/csp_front.sv
rtl/core/csp_queue.sv
rtl/core/csp_back.sv
rtl/core/cigar_string_parser_unit.sv
tb/cigar_string_parser_unit_tb.sv
